// File: hw/rtl/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types, codes and the AES S-box for the tweaked CMAC tag engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    localparam int BLOCK_BITS  = 128;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic       CMD_ABSORB = 1'b0;
    localparam logic       CMD_FINISH = 1'b1;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_TWEAK    = 2'd2;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] DBL_POLY  = 8'h87;
    localparam logic [4:0] FULL_FILL = 5'd16;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [BLOCK_BITS-1:0] dbl(input logic [BLOCK_BITS-1:0] v);
        return {v[BLOCK_BITS-2:0], 1'b0} ^ {{(BLOCK_BITS-8){1'b0}}, (v[BLOCK_BITS-1] ? DBL_POLY : 8'h00)};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tce_front.sv
// ----------------------------------------------------------------------------
// tce_front
// Input side: accept items and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tce_pkg::t_item i_item,
    output tce_pkg::t_qhead     o_head,
    input  wire logic           i_pop
);
    import tce_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                push;

    assign o_in_ready  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(i_pop);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tce_aes.sv
// ----------------------------------------------------------------------------
// tce_aes
// Iterative AES-128 encryption, one round per cycle, key expanded on the fly.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_aes (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_block,
    input  wire logic [127:0] i_key,
    output logic              o_done,
    output logic [127:0]      o_result
);
    import tce_pkg::*;

    logic [127:0] r_st, r_rk;
    logic [7:0]   r_rcon;
    logic [3:0]   r_round;
    logic         r_busy, r_done;

    logic [7:0]   st [16];
    logic [7:0]   rk [16];
    logic [7:0]   sb [16];
    logic [7:0]   mx [16];
    logic [7:0]   nrk [16];
    logic [7:0]   t [4];
    logic [127:0] n_st, n_rk;

    always_comb begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++) begin
            st[i] = r_st[8*i +: 8];
            rk[i] = r_rk[8*i +: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[c*4+r] = SBOX[st[((c + r) & 3)*4 + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = sb[c*4];
            a1  = sb[c*4+1];
            a2  = sb[c*4+2];
            a3  = sb[c*4+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (r_round != LAST_ROUND) begin
                mx[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
                mx[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
                mx[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
                mx[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end else begin
                mx[c*4]   = a0;
                mx[c*4+1] = a1;
                mx[c*4+2] = a2;
                mx[c*4+3] = a3;
            end
        end
        t[0] = SBOX[rk[13]] ^ r_rcon;
        t[1] = SBOX[rk[14]];
        t[2] = SBOX[rk[15]];
        t[3] = SBOX[rk[12]];
        for (int i = 0; i < 4; i++) begin
            nrk[i] = rk[i] ^ t[i];
        end
        for (int i = 4; i < 16; i++) begin
            nrk[i] = rk[i] ^ nrk[i-4];
        end
        for (int i = 0; i < 16; i++) begin
            n_rk[8*i +: 8] = nrk[i];
            n_st[8*i +: 8] = mx[i] ^ nrk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_st <= i_block ^ i_key;
            r_rk <= i_key;
        end else if (r_busy) begin
            r_st <= n_st;
            r_rk <= n_rk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= 4'd1;
            r_rcon  <= 8'h01;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
                r_rcon  <= 8'h01;
            end else if (r_busy) begin
                r_round <= r_round + 1'b1;
                r_rcon  <= xtime(r_rcon);
                if (r_round == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_st;

endmodule

`default_nettype wire

// File: hw/rtl/tce_back.sv
// ----------------------------------------------------------------------------
// tce_back
// Execution side: subkeys, block buffer, chaining value and tag register.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tce_pkg::t_qhead i_head,
    output logic                 o_pop,
    input  wire logic [127:0]    i_key,
    input  wire logic            i_tweak_select,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [127:0]         o_tag
);
    import tce_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_ABS  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]   r_state;
    t_item        r_item;
    logic [127:0] r_buf, r_chain, r_d, r_q, r_tag;
    logic [4:0]   r_fill;
    logic         r_open, r_out_valid;

    logic         aes_start, aes_done;
    logic [127:0] aes_in, aes_out, last_blk, sub_d;

    assign o_pop = (r_state == S_IDLE) && i_head.valid;
    assign sub_d = dbl(aes_out);

    always_comb begin
        logic [7:0] b;
        for (int i = 0; i < 16; i++) begin
            if (r_fill == FULL_FILL) begin
                b = r_buf[8*i +: 8] ^ r_d[8*i +: 8];
            end else begin
                if (5'(i) < r_fill) begin
                    b = r_buf[8*i +: 8];
                end else if (5'(i) == r_fill) begin
                    b = PAD_BYTE;
                end else begin
                    b = 8'h00;
                end
                b = b ^ r_q[8*i +: 8];
            end
            last_blk[8*i +: 8] = b;
        end
    end

    always_comb begin
        aes_start = 1'b0;
        aes_in    = r_chain ^ r_buf;
        if (o_pop && !r_open) begin
            aes_start = 1'b1;
            aes_in    = '0;
        end else if (r_state == S_EXEC) begin
            if (r_item.cmd == CMD_ABSORB) begin
                aes_start = (r_fill == FULL_FILL);
            end else begin
                aes_start = !r_out_valid;
                aes_in    = r_chain ^ last_blk;
            end
        end
    end

    tce_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (aes_start),
        .i_block  (aes_in),
        .i_key    (i_key),
        .o_done   (aes_done),
        .o_result (aes_out)
    );

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head.item;
        end
        if (r_state == S_SUB && aes_done) begin
            r_d     <= sub_d;
            r_q     <= dbl(sub_d);
            r_chain <= i_tweak_select ? dbl(sub_d) : sub_d;
        end
        if (r_state == S_EXEC && r_item.cmd == CMD_ABSORB && r_fill != FULL_FILL) begin
            r_buf[8*r_fill[3:0] +: 8] <= r_item.data_byte;
        end
        if (r_state == S_ABS && aes_done) begin
            r_chain       <= aes_out;
            r_buf[7:0]    <= r_item.data_byte;
        end
        if (r_state == S_FIN && aes_done) begin
            r_tag <= aes_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= r_open ? S_EXEC : S_SUB;
                    end
                end
                S_SUB: begin
                    if (aes_done) begin
                        r_open  <= 1'b1;
                        r_fill  <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_item.cmd == CMD_ABSORB) begin
                        if (r_fill == FULL_FILL) begin
                            r_state <= S_ABS;
                        end else begin
                            r_fill  <= r_fill + 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (!r_out_valid) begin
                        r_state <= S_FIN;
                    end
                end
                S_ABS: begin
                    if (aes_done) begin
                        r_fill  <= 5'd1;
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (aes_done) begin
                        r_out_valid <= 1'b1;
                        r_open      <= 1'b0;
                        r_fill      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tag       = r_tag;

endmodule

`default_nettype wire

// File: hw/rtl/tweaked_cmac_tag_engine.sv
// ----------------------------------------------------------------------------
// tweaked_cmac_tag_engine
// AES-128 CMAC tag over a byte stream with a D/Q chain start (EAX style).
//
//   channel   signals                                  direction
//   in        i_in_valid/o_in_ready, i_cmd, i_data_byte  in
//   out       o_out_valid/i_out_ready, o_tag_low/high    out
//   cfg       i_cfg_we, i_cfg_idx, i_cfg_data            in
//
// Each byte passes the back end's EXEC state; a byte that meets a full block
// buffer first runs AES on it, the first item of a message first runs AES for
// the subkey, and a finish runs AES for the tag, all on the single iterative
// AES unit. A four-entry queue absorbs input while the back end works.
// Reset is synchronous, active low; a pending tag stalls further finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module tweaked_cmac_tag_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_tag_low,
    output logic [63:0]      o_tag_high,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    import tce_pkg::*;

    logic [63:0]  r_key_low, r_key_high;
    logic         r_tweak;
    t_item        in_item;
    t_qhead       head;
    logic         pop;
    logic [127:0] tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_tweak    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_TWEAK:    r_tweak    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.cmd       = i_cmd;
    assign in_item.data_byte = i_data_byte;

    tce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (in_item),
        .o_head     (head),
        .i_pop      (pop)
    );

    tce_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .i_key          ({r_key_high, r_key_low}),
        .i_tweak_select (r_tweak),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tag          (tag)
    );

    assign o_tag_low  = tag[63:0];
    assign o_tag_high = tag[127:64];

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    a_pop_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !pop)
        else $error("back end popped twice in a row");

endmodule

`default_nettype wire

// File: tb/tb_tweaked_cmac_tag_engine.sv
// ----------------------------------------------------------------------------
// tb_tweaked_cmac_tag_engine
// Self-checking bench for the CMAC tag engine: a directed table of short
// messages, then random messages under several key and tweak settings and
// idle/stall mixes. Every tag is compared against an in-bench AES-128 CMAC.
// ----------------------------------------------------------------------------
module tb_tweaked_cmac_tag_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import tce_pkg::*;

    localparam int LIMIT = 600000;
    localparam int DRAIN = 64;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready, i_cmd;
    logic [7:0]  i_data_byte;
    logic        o_out_valid, i_out_ready;
    logic [63:0] o_tag_low, o_tag_high;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    tweaked_cmac_tag_engine DUT (.*);

    logic [7:0]   sbox_tab [256];
    logic [127:0] cipher_key;
    logic         tweak_q;
    logic [127:0] msg_block, chain, sub_d, sub_q;
    int           fill;
    logic         msg_open;
    logic [127:0] tags_due [$];
    int           errors;
    int           cycles;
    int           idle_pct, stall_pct;
    t_row         directed [$];

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    task automatic build_sbox();
        logic [7:0] inv, b;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gmul(inv, x[7:0]);
            if (x == 0) inv = 8'h00;
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_tab[x] = b;
        end
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
        logic [127:0] rk, s, t;
        logic [7:0]   rc, a0, a1, a2, a3, all;
        logic [7:0]   tw [4];
        rk = cipher_key;
        s  = pt ^ rk;
        rc = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[8*(c*4+r) +: 8] = sbox_tab[s[8*(((c+r)&3)*4+r) +: 8]];
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[8*(c*4) +: 8];   a1 = t[8*(c*4+1) +: 8];
                    a2 = t[8*(c*4+2) +: 8]; a3 = t[8*(c*4+3) +: 8];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[8*(c*4) +: 8]   = a0 ^ all ^ gmul(a0 ^ a1, 8'h02);
                    t[8*(c*4+1) +: 8] = a1 ^ all ^ gmul(a1 ^ a2, 8'h02);
                    t[8*(c*4+2) +: 8] = a2 ^ all ^ gmul(a2 ^ a3, 8'h02);
                    t[8*(c*4+3) +: 8] = a3 ^ all ^ gmul(a3 ^ a0, 8'h02);
                end
            end
            tw[0] = sbox_tab[rk[8*13 +: 8]] ^ rc;
            tw[1] = sbox_tab[rk[8*14 +: 8]];
            tw[2] = sbox_tab[rk[8*15 +: 8]];
            tw[3] = sbox_tab[rk[8*12 +: 8]];
            rc = gmul(rc, 8'h02);
            for (int i = 0; i < 4; i++) rk[8*i +: 8] ^= tw[i];
            for (int i = 4; i < 16; i++) rk[8*i +: 8] ^= rk[8*(i-4) +: 8];
            s = t ^ rk;
        end
        return s;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

    task automatic predict_tag(input logic cmd, input logic [7:0] data);
        logic [127:0] last;
        if (!msg_open) begin
            sub_d = gf_double(aes_encrypt(128'h0));
            sub_q = gf_double(sub_d);
            chain = tweak_q ? sub_q : sub_d;
            fill = 0;
            msg_open = 1'b1;
        end
        if (cmd == CMD_ABSORB) begin
            if (fill >= 16) begin
                chain = aes_encrypt(chain ^ msg_block);
                fill = 0;
            end
            msg_block[8*fill +: 8] = data;
            fill++;
        end else begin
            if (fill >= 16) begin
                last = msg_block ^ sub_d;
            end else begin
                last = 128'h0;
                for (int i = 0; i < fill; i++) last[8*i +: 8] = msg_block[8*i +: 8];
                last[8*fill +: 8] = 8'h80;
                last ^= sub_q;
            end
            tags_due.push_back(aes_encrypt(chain ^ last));
            fill = 0;
            msg_open = 1'b0;
        end
    endtask

    task automatic send(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_cmd       = cmd;
        i_data_byte = data;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tag(cmd, data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        while (tags_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_KEY_LOW:  cipher_key[63:0]   = val;
            REG_KEY_HIGH: cipher_key[127:64] = val;
            default:      tweak_q            = val[0];
        endcase
    endtask

    task automatic random_messages(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(20);
            if ($urandom_range(4) == 0) len = 16 * $urandom_range(2);
            for (int k = 0; k < len; k++) send(CMD_ABSORB, 8'($urandom_range(255)));
            send(CMD_FINISH, 8'($urandom_range(255)));
            sent += len + 1;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) i_out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tags_due.size() == 0) begin
                $display("%0t: unexpected tag %h_%h", $realtime, o_tag_high, o_tag_low);
                errors++;
            end else begin
                if (tags_due[0][63:0] !== o_tag_low)
                    $display("%0t: tag_low exp %h got %h", $realtime,
                             tags_due[0][63:0], o_tag_low);
                if (tags_due[0][127:64] !== o_tag_high)
                    $display("%0t: tag_high exp %h got %h", $realtime,
                             tags_due[0][127:64], o_tag_high);
                if ({o_tag_high, o_tag_low} !== tags_due[0]) errors++;
                void'(tags_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        errors = 0; cycles = 0;
        idle_pct = 0; stall_pct = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_cmd = CMD_ABSORB; i_data_byte = 8'h00;
        i_out_ready = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = REG_KEY_LOW; i_cfg_data = '0;
        cipher_key = '0; tweak_q = 1'b0; msg_open = 1'b0; fill = 0;
        msg_block = '0; chain = '0; sub_d = '0; sub_q = '0;
        build_sbox();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message, two extreme bytes, then one exact full block
        directed.push_back('{CMD_FINISH, 8'h00});
        directed.push_back('{CMD_ABSORB, 8'h00});
        directed.push_back('{CMD_ABSORB, 8'hff});
        directed.push_back('{CMD_FINISH, 8'hff});
        for (int k = 0; k < 16; k++)
            directed.push_back('{CMD_ABSORB, (k[0] ? 8'hff : 8'h00) ^ k[7:0]});
        directed.push_back('{CMD_FINISH, 8'h00});
        foreach (directed[r]) send(directed[r].cmd, directed[r].data_byte);

        write_reg(REG_TWEAK, 64'h1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        random_messages(200);

        idle_pct = 82;
        write_reg(REG_TWEAK, 64'h0);
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        random_messages(200);

        idle_pct = 0; stall_pct = 82;
        write_reg(REG_TWEAK, 64'h1);
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        random_messages(200);

        idle_pct = 25; stall_pct = 25;
        write_reg(REG_TWEAK, 64'h0);
        write_reg(REG_KEY_LOW, '0);
        write_reg(REG_KEY_HIGH, '0);
        random_messages(200);

        while (tags_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
